// ===== rtl/constant_fold_peephole_macros.svh =====
// assertion macros shared by the constant folding peephole rtl
`ifndef CONSTANT_FOLD_PEEPHOLE_MACROS_SVH
`define CONSTANT_FOLD_PEEPHOLE_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define CFP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after its trigger
`define CFP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cfp_pkg.sv =====
// shared types and constants of the constant folding peephole
`timescale 1ns / 1ps

package cfp_pkg;

    // opcode and configuration widths
    localparam int OPCODE_BITS = 8;
    localparam int CFG_IDX_BITS = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_PUSH = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NOP  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ADD  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SUB  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MUL  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIV  = 3'd5;

    // opcode reset values
    localparam logic [OPCODE_BITS-1:0] PUSH_RST = 8'd0;
    localparam logic [OPCODE_BITS-1:0] NOP_RST  = 8'd1;
    localparam logic [OPCODE_BITS-1:0] ADD_RST  = 8'd2;
    localparam logic [OPCODE_BITS-1:0] SUB_RST  = 8'd3;
    localparam logic [OPCODE_BITS-1:0] MUL_RST  = 8'd4;
    localparam logic [OPCODE_BITS-1:0] DIV_RST  = 8'd5;

    // binary64 working exponent and constants
    localparam int EXP_W = 14;
    localparam logic signed [EXP_W-1:0] E_ONE    = 14'sd1;
    localparam logic signed [EXP_W-1:0] E_BIAS   = 14'sd1023;
    localparam logic signed [EXP_W-1:0] E_MAX    = 14'sd2047;
    localparam logic signed [EXP_W-1:0] E_FLOOR  = -14'sd60;
    localparam logic signed [EXP_W-1:0] ALIGN_MAX = 14'sd60;
    localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
    localparam logic [63:0] DEF_NAN   = 64'hFFF8_0000_0000_0000;
    localparam logic [5:0]  MUL_STEPS = 6'd53;
    localparam logic [5:0]  DIV_STEPS = 6'd56;

    // arithmetic operation of a fold
    typedef enum logic [1:0] {
        FOP_ADD,
        FOP_SUB,
        FOP_MUL,
        FOP_DIV
    } fop_e_t;

    // sequencer of the floating point unit
    typedef enum logic [3:0] {
        F_IDLE,
        F_PRE_A,
        F_PRE_B,
        F_SETUP,
        F_ALIGN,
        F_ADD,
        F_MUL,
        F_DIV,
        F_NORM,
        F_ROUND,
        F_DONE
    } fpu_state_t;

    // top level control
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLD,
        ST_EMIT
    } top_state_t;

    // request into the floating point unit
    typedef struct packed {
        logic        start;
        fop_e_t      op;
        logic [63:0] a;
        logic [63:0] b;
    } fpu_req_t;

    // response from the floating point unit
    typedef struct packed {
        logic        done;
        logic [63:0] value;
    } fpu_rsp_t;

endpackage

// ===== rtl/cfp_fpu.sv =====
// iterative binary64 add, subtract, multiply and divide unit
`timescale 1ns / 1ps

module cfp_fpu import cfp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  fpu_req_t req,
    output fpu_rsp_t rsp
);

    fpu_state_t state_reg, state_next;
    fop_e_t     op_reg, op_next;
    logic       sa_reg, sa_next;
    logic       sb_reg, sb_next;
    logic       sign_reg, sign_next;
    logic       esub_reg, esub_next;
    logic signed [EXP_W-1:0] ea_reg, ea_next, eb_reg, eb_next, e_reg, e_next;
    logic [52:0]  ma_reg, ma_next, mb_reg, mb_next;
    logic [56:0]  m_reg, m_next;
    logic [105:0] prod_reg, prod_next;
    logic [54:0]  rem_reg, rem_next;
    logic [55:0]  q_reg, q_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic [63:0]  res_reg, res_next;

    // operand classification
    logic [10:0] a_ef, b_ef;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, b_seff, x_sgn;
    logic        spec_hit;
    logic [63:0] spec_val;

    assign a_ef   = req.a[62:52];
    assign b_ef   = req.b[62:52];
    assign a_nan  = (a_ef == 11'h7FF) && (req.a[51:0] != 52'd0);
    assign b_nan  = (b_ef == 11'h7FF) && (req.b[51:0] != 52'd0);
    assign a_inf  = (a_ef == 11'h7FF) && (req.a[51:0] == 52'd0);
    assign b_inf  = (b_ef == 11'h7FF) && (req.b[51:0] == 52'd0);
    assign a_zero = (req.a[62:0] == 63'd0);
    assign b_zero = (req.b[62:0] == 63'd0);
    assign b_seff = req.b[63] ^ (req.op == FOP_SUB);
    assign x_sgn  = req.a[63] ^ req.b[63];

    // nan, infinity and zero operands bypass the iteration
    always_comb begin
        spec_hit = 1'b1;
        spec_val = 64'd0;
        if (a_nan) begin
            spec_val = req.a | QUIET_BIT;
        end else if (b_nan) begin
            spec_val = req.b | QUIET_BIT;
        end else begin
            case (req.op)
                FOP_ADD, FOP_SUB: begin
                    if (a_inf && b_inf && (req.a[63] != b_seff)) begin
                        spec_val = DEF_NAN;
                    end else if (a_inf) begin
                        spec_val = req.a;
                    end else if (b_inf) begin
                        spec_val = {b_seff, req.b[62:0]};
                    end else if (a_zero && b_zero) begin
                        spec_val = {req.a[63] & b_seff, 63'd0};
                    end else if (a_zero) begin
                        spec_val = {b_seff, req.b[62:0]};
                    end else if (b_zero) begin
                        spec_val = req.a;
                    end else begin
                        spec_hit = 1'b0;
                    end
                end
                FOP_MUL: begin
                    if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                        spec_val = DEF_NAN;
                    end else if (a_inf || b_inf) begin
                        spec_val = {x_sgn, 11'h7FF, 52'd0};
                    end else if (a_zero || b_zero) begin
                        spec_val = {x_sgn, 63'd0};
                    end else begin
                        spec_hit = 1'b0;
                    end
                end
                FOP_DIV: begin
                    if ((a_inf && b_inf) || (a_zero && b_zero)) begin
                        spec_val = DEF_NAN;
                    end else if (a_inf || b_zero) begin
                        spec_val = {x_sgn, 11'h7FF, 52'd0};
                    end else if (b_inf || a_zero) begin
                        spec_val = {x_sgn, 63'd0};
                    end else begin
                        spec_hit = 1'b0;
                    end
                end
                default: spec_hit = 1'b0;
            endcase
        end
    end

    // shared adder / subtractor
    logic [56:0] alu_x, alu_y;
    logic        alu_sub;
    logic [57:0] alu_sum;

    always_comb begin
        alu_x   = 57'd0;
        alu_y   = 57'd0;
        alu_sub = 1'b0;
        case (state_reg)
            F_MUL: begin
                alu_x = {4'd0, prod_reg[105:53]};
                alu_y = mb_reg[0] ? {4'd0, ma_reg} : 57'd0;
            end
            F_DIV: begin
                alu_x   = {2'd0, rem_reg};
                alu_y   = {4'd0, mb_reg};
                alu_sub = 1'b1;
            end
            F_ADD: begin
                alu_x   = {1'b0, ma_reg, 3'd0};
                alu_y   = m_reg;
                alu_sub = esub_reg;
            end
            default: alu_sub = 1'b0;
        endcase
    end

    assign alu_sum = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)} + {57'd0, alu_sub};

    // magnitude order and exponent gap for add / subtract
    logic                    a_ge, far_gap;
    logic signed [EXP_W-1:0] gap;

    assign a_ge    = (ea_reg > eb_reg) || ((ea_reg == eb_reg) && (ma_reg >= mb_reg));
    assign gap     = a_ge ? (ea_reg - eb_reg) : (eb_reg - ea_reg);
    assign far_gap = gap > ALIGN_MAX;

    // divide step
    logic        div_ge;
    logic [54:0] div_rem;

    assign div_ge  = alu_sum[57];
    assign div_rem = div_ge ? alu_sum[54:0] : rem_reg;

    // rounding to nearest even
    logic                    rnd_inc;
    logic [53:0]             rnd_m;
    logic signed [EXP_W-1:0] rnd_e;
    logic [63:0]             rnd_val;

    assign rnd_inc = m_reg[2] & (m_reg[3] | m_reg[1] | m_reg[0]);
    assign rnd_m   = {1'b0, m_reg[55:3]} + {53'd0, rnd_inc};
    assign rnd_e   = e_reg + (rnd_m[53] ? E_ONE : '0);

    always_comb begin
        if (rnd_e >= E_MAX) begin
            rnd_val = {sign_reg, 11'h7FF, 52'd0};
        end else if (rnd_m[53]) begin
            rnd_val = {sign_reg, rnd_e[10:0], 52'd0};
        end else begin
            rnd_val = {sign_reg, (rnd_m[52] ? e_reg[10:0] : 11'd0), rnd_m[51:0]};
        end
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (req.start) begin
                    state_next = spec_hit ? F_DONE : F_PRE_A;
                end
            end
            F_PRE_A: if (ma_reg[52]) state_next = F_PRE_B;
            F_PRE_B: if (mb_reg[52]) state_next = F_SETUP;
            F_SETUP: begin
                case (op_reg)
                    FOP_MUL: state_next = F_MUL;
                    FOP_DIV: state_next = F_DIV;
                    default: state_next = F_ALIGN;
                endcase
            end
            F_ALIGN: if (cnt_reg == 6'd0) state_next = F_ADD;
            F_ADD:   state_next = (alu_sum[56:0] == 57'd0) ? F_DONE : F_NORM;
            F_MUL:   if (cnt_reg == 6'd0) state_next = F_NORM;
            F_DIV:   if (cnt_reg == 6'd0) state_next = F_NORM;
            F_NORM: begin
                if (!(e_reg < E_FLOOR) && !m_reg[56] && !(e_reg < E_ONE)
                    && !(!m_reg[55] && (e_reg > E_ONE))) begin
                    state_next = F_ROUND;
                end
            end
            F_ROUND: state_next = F_DONE;
            F_DONE:  state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        op_next   = op_reg;
        sa_next   = sa_reg;
        sb_next   = sb_reg;
        sign_next = sign_reg;
        esub_next = esub_reg;
        ea_next   = ea_reg;
        eb_next   = eb_reg;
        e_next    = e_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        m_next    = m_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        res_next  = res_reg;
        case (state_reg)
            F_IDLE: begin
                if (req.start) begin
                    res_next = spec_val;
                    op_next  = req.op;
                    sa_next  = req.a[63];
                    sb_next  = b_seff;
                    ea_next  = (a_ef == 11'd0) ? E_ONE : {3'd0, a_ef};
                    eb_next  = (b_ef == 11'd0) ? E_ONE : {3'd0, b_ef};
                    ma_next  = {a_ef != 11'd0, req.a[51:0]};
                    mb_next  = {b_ef != 11'd0, req.b[51:0]};
                end
            end
            // subnormal operands get a hidden one
            F_PRE_A: begin
                if (!ma_reg[52]) begin
                    ma_next = {ma_reg[51:0], 1'b0};
                    ea_next = ea_reg - E_ONE;
                end
            end
            F_PRE_B: begin
                if (!mb_reg[52]) begin
                    mb_next = {mb_reg[51:0], 1'b0};
                    eb_next = eb_reg - E_ONE;
                end
            end
            F_SETUP: begin
                case (op_reg)
                    FOP_MUL: begin
                        prod_next = 106'd0;
                        cnt_next  = MUL_STEPS;
                        e_next    = ea_reg + eb_reg - E_BIAS;
                        sign_next = sa_reg ^ sb_reg;
                    end
                    FOP_DIV: begin
                        rem_next  = {2'd0, ma_reg};
                        q_next    = 56'd0;
                        cnt_next  = DIV_STEPS;
                        e_next    = ea_reg - eb_reg + E_BIAS;
                        sign_next = sa_reg ^ sb_reg;
                    end
                    default: begin
                        esub_next = sa_reg ^ sb_reg;
                        sign_next = a_ge ? sa_reg : sb_reg;
                        e_next    = a_ge ? ea_reg : eb_reg;
                        ma_next   = a_ge ? ma_reg : mb_reg;
                        if (far_gap) begin
                            m_next   = 57'd1;
                            cnt_next = 6'd0;
                        end else begin
                            m_next   = {1'b0, (a_ge ? mb_reg : ma_reg), 3'd0};
                            cnt_next = gap[5:0];
                        end
                    end
                endcase
            end
            // smaller operand shifts right one bit a cycle, keeping sticky
            F_ALIGN: begin
                if (cnt_reg != 6'd0) begin
                    m_next   = {1'b0, m_reg[56:2], m_reg[1] | m_reg[0]};
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            F_ADD: begin
                m_next   = alu_sum[56:0];
                res_next = 64'd0;
            end
            // shift and add, one multiplier bit a cycle
            F_MUL: begin
                if (cnt_reg == 6'd0) begin
                    m_next = {prod_reg[105:50], prod_reg[49] | (prod_reg[48:0] != 49'd0)};
                end else begin
                    prod_next = {alu_sum[53:0], prod_reg[52:1]};
                    mb_next   = {1'b0, mb_reg[52:1]};
                    cnt_next  = cnt_reg - 6'd1;
                end
            end
            // restoring divide, one quotient bit a cycle
            F_DIV: begin
                if (cnt_reg == 6'd0) begin
                    m_next = {1'b0, q_reg[55:1], q_reg[0] | (rem_reg != 55'd0)};
                end else begin
                    q_next   = {q_reg[54:0], div_ge};
                    rem_next = {div_rem[53:0], 1'b0};
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            F_NORM: begin
                if (e_reg < E_FLOOR) begin
                    m_next = {56'd0, m_reg != 57'd0};
                    e_next = E_ONE;
                end else if (m_reg[56] || (e_reg < E_ONE)) begin
                    m_next = {1'b0, m_reg[56:2], m_reg[1] | m_reg[0]};
                    e_next = e_reg + E_ONE;
                end else if (!m_reg[55] && (e_reg > E_ONE)) begin
                    m_next = {m_reg[55:0], 1'b0};
                    e_next = e_reg - E_ONE;
                end
            end
            F_ROUND: res_next = rnd_val;
            default: res_next = res_reg;
        endcase
    end

    assign rsp.done  = (state_reg == F_DONE);
    assign rsp.value = res_reg;

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        sa_reg   <= sa_next;
        sb_reg   <= sb_next;
        sign_reg <= sign_next;
        esub_reg <= esub_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        e_reg    <= e_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        m_reg    <= m_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

endmodule

// ===== rtl/constant_fold_peephole.sv =====
// top level of the constant folding peephole
`timescale 1ns / 1ps
`include "constant_fold_peephole_macros.svh"

// Peephole constant folder. Instructions enter one at a time on s_*; rewritten
// instructions leave in program order on m_*, up to three per input item. An item
// that does not fold enters and then releases its items; s_ready stays low until
// the last of them is taken. A fold runs in the shared binary64 unit, which works
// one bit a cycle: it looks at each operand for the hidden one and shifts a
// subnormal operand left (up to 52 places), runs a setup step, then a multiply, a
// divide or an add/subtract (alignment shifts plus the sum), then the normalizing
// steps, rounds and hands the result over. The user must write the opcode
// registers on cfg_* only while the block is idle; the block itself does not
// enforce this.
module constant_fold_peephole import cfp_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [OPCODE_BITS-1:0]  cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OPCODE_BITS-1:0]  s_instr_opcode,
    input  logic [63:0]             s_instr_value,
    input  logic                    s_last_instr,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [OPCODE_BITS-1:0]  m_out_opcode,
    output logic [63:0]             m_out_value,
    output logic                    m_out_last
);

    top_state_t state_reg, state_next;
    logic [OPCODE_BITS-1:0] push_reg, push_next, nop_reg, nop_next;
    logic [OPCODE_BITS-1:0] add_reg, add_next, sub_reg, sub_next;
    logic [OPCODE_BITS-1:0] mul_reg, mul_next, div_reg, div_next;
    logic [1:0]             held_cnt_reg, held_cnt_next;
    logic [OPCODE_BITS-1:0] older_op_reg, older_op_next, newer_op_reg, newer_op_next;
    logic [63:0]            older_val_reg, older_val_next, newer_val_reg, newer_val_next;
    logic [OPCODE_BITS-1:0] q_op_reg [0:2];
    logic [OPCODE_BITS-1:0] q_op_next [0:2];
    logic [63:0]            q_val_reg [0:2];
    logic [63:0]            q_val_next [0:2];
    logic                   q_last_reg [0:2];
    logic                   q_last_next [0:2];
    logic [1:0]             out_cnt_reg, out_cnt_next, out_idx_reg, out_idx_next;

    fpu_req_t fpu_req;
    fpu_rsp_t fpu_rsp;

    logic   accept, both_push, is_add, is_sub, is_mul, is_div, div_ok, fold_hit;
    logic   m_take, emit_end;
    fop_e_t fold_op;

    assign accept   = s_valid && s_ready;
    assign m_take   = m_valid && m_ready;
    assign emit_end = (out_idx_reg == (out_cnt_reg - 2'd1));

    // fold detection, operations ranked add, sub, mul, div
    assign both_push = (held_cnt_reg == 2'd2) && (older_op_reg == push_reg)
                       && (newer_op_reg == push_reg);
    assign is_add = (s_instr_opcode == add_reg);
    assign is_sub = (s_instr_opcode == sub_reg);
    assign is_mul = (s_instr_opcode == mul_reg);
    assign is_div = (s_instr_opcode == div_reg);
    assign div_ok = (newer_val_reg[62:0] != 63'd0);
    assign fold_hit = both_push && (is_add || is_sub || is_mul || (is_div && div_ok));

    always_comb begin
        if (is_add) begin
            fold_op = FOP_ADD;
        end else if (is_sub) begin
            fold_op = FOP_SUB;
        end else if (is_mul) begin
            fold_op = FOP_MUL;
        end else begin
            fold_op = FOP_DIV;
        end
    end

    assign fpu_req.start = accept && fold_hit;
    assign fpu_req.op    = fold_op;
    assign fpu_req.a     = older_val_reg;
    assign fpu_req.b     = newer_val_reg;

    cfp_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fpu_req),
        .rsp     (fpu_rsp)
    );

    // opcode registers
    always_comb begin
        push_next = push_reg;
        nop_next  = nop_reg;
        add_next  = add_reg;
        sub_next  = sub_reg;
        mul_next  = mul_reg;
        div_next  = div_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PUSH: push_next = cfg_wr_data;
                CFG_NOP:  nop_next  = cfg_wr_data;
                CFG_ADD:  add_next  = cfg_wr_data;
                CFG_SUB:  sub_next  = cfg_wr_data;
                CFG_MUL:  mul_next  = cfg_wr_data;
                CFG_DIV:  div_next  = cfg_wr_data;
                default:  push_next = push_reg;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (fold_hit) begin
                        state_next = ST_FOLD;
                    end else if (out_cnt_next != 2'd0) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_FOLD: if (fpu_rsp.done) state_next = ST_EMIT;
            ST_EMIT: if (m_take && emit_end) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // window and item queue
    always_comb begin
        held_cnt_next  = held_cnt_reg;
        older_op_next  = older_op_reg;
        older_val_next = older_val_reg;
        newer_op_next  = newer_op_reg;
        newer_val_next = newer_val_reg;
        out_cnt_next   = out_cnt_reg;
        out_idx_next   = out_idx_reg;
        for (int i = 0; i < 3; i++) begin
            q_op_next[i]   = q_op_reg[i];
            q_val_next[i]  = q_val_reg[i];
            q_last_next[i] = q_last_reg[i];
        end
        if (accept) begin
            out_idx_next = 2'd0;
            if (fold_hit) begin
                held_cnt_next  = 2'd0;
                out_cnt_next   = 2'd3;
                q_op_next[0]   = push_reg;
                q_last_next[0] = 1'b0;
                q_op_next[1]   = nop_reg;
                q_val_next[1]  = newer_val_reg;
                q_last_next[1] = 1'b0;
                q_op_next[2]   = nop_reg;
                q_val_next[2]  = s_instr_value;
                q_last_next[2] = s_last_instr;
            end else begin
                // held items in age order, then the arriving one
                case (held_cnt_reg)
                    2'd0: begin
                        q_op_next[0]   = s_instr_opcode;
                        q_val_next[0]  = s_instr_value;
                        q_last_next[0] = s_last_instr;
                    end
                    2'd1: begin
                        q_op_next[0]   = newer_op_reg;
                        q_val_next[0]  = newer_val_reg;
                        q_last_next[0] = 1'b0;
                        q_op_next[1]   = s_instr_opcode;
                        q_val_next[1]  = s_instr_value;
                        q_last_next[1] = s_last_instr;
                    end
                    default: begin
                        q_op_next[0]   = older_op_reg;
                        q_val_next[0]  = older_val_reg;
                        q_last_next[0] = 1'b0;
                        q_op_next[1]   = newer_op_reg;
                        q_val_next[1]  = newer_val_reg;
                        q_last_next[1] = 1'b0;
                        q_op_next[2]   = s_instr_opcode;
                        q_val_next[2]  = s_instr_value;
                        q_last_next[2] = s_last_instr;
                    end
                endcase
                if (s_last_instr) begin
                    held_cnt_next = 2'd0;
                    out_cnt_next  = held_cnt_reg + 2'd1;
                end else begin
                    held_cnt_next = (held_cnt_reg == 2'd0) ? 2'd1 : 2'd2;
                    out_cnt_next  = (held_cnt_reg == 2'd2) ? 2'd1 : 2'd0;
                end
                if (held_cnt_reg != 2'd0) begin
                    older_op_next  = newer_op_reg;
                    older_val_next = newer_val_reg;
                end
                newer_op_next  = s_instr_opcode;
                newer_val_next = s_instr_value;
            end
        end
        if ((state_reg == ST_FOLD) && fpu_rsp.done) begin
            q_val_next[0] = fpu_rsp.value;
        end
        if (m_take) begin
            out_idx_next = emit_end ? 2'd0 : (out_idx_reg + 2'd1);
        end
    end

    // handshake outputs
    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        m_valid      = (state_reg == ST_EMIT);
        m_out_opcode = q_op_reg[out_idx_reg];
        m_out_value  = q_val_reg[out_idx_reg];
        m_out_last   = q_last_reg[out_idx_reg];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            held_cnt_reg <= 2'd0;
            out_cnt_reg  <= 2'd0;
            out_idx_reg  <= 2'd0;
            push_reg     <= PUSH_RST;
            nop_reg      <= NOP_RST;
            add_reg      <= ADD_RST;
            sub_reg      <= SUB_RST;
            mul_reg      <= MUL_RST;
            div_reg      <= DIV_RST;
        end else begin
            state_reg    <= state_next;
            held_cnt_reg <= held_cnt_next;
            out_cnt_reg  <= out_cnt_next;
            out_idx_reg  <= out_idx_next;
            push_reg     <= push_next;
            nop_reg      <= nop_next;
            add_reg      <= add_next;
            sub_reg      <= sub_next;
            mul_reg      <= mul_next;
            div_reg      <= div_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        older_op_reg  <= older_op_next;
        older_val_reg <= older_val_next;
        newer_op_reg  <= newer_op_next;
        newer_val_reg <= newer_val_next;
        for (int i = 0; i < 3; i++) begin
            q_op_reg[i]   <= q_op_next[i];
            q_val_reg[i]  <= q_val_next[i];
            q_last_reg[i] <= q_last_next[i];
        end
    end

    // checks
    `CFP_ASSERT_NOW(a_no_overlap, aclk, aresetn, m_valid, !s_ready, "input taken while items wait")
    `CFP_ASSERT_NEXT(a_fold_start, aclk, aresetn, fpu_req.start, state_reg == ST_FOLD, "fold not started")
    `CFP_ASSERT_NOW(a_fold_done, aclk, aresetn, fpu_rsp.done, (state_reg == ST_FOLD) && (out_cnt_reg == 2'd3), "stray fold result")
    `CFP_ASSERT_NOW(a_held_range, aclk, aresetn, 1'b1, held_cnt_reg != 2'd3, "window overfull")

endmodule

// ===== test/cfp_fold_checker.sv =====
// checker for the constant folding peephole: predicts and compares the rewritten stream
`timescale 1ns / 1ps

module cfp_fold_checker import cfp_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [OPCODE_BITS-1:0]  cfg_wr_data,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [OPCODE_BITS-1:0]  s_instr_opcode,
    input  logic [63:0]             s_instr_value,
    input  logic                    s_last_instr,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [OPCODE_BITS-1:0]  m_out_opcode,
    input  logic [63:0]             m_out_value,
    input  logic                    m_out_last,
    output int                      pending_count,
    output int                      mismatch_count,
    output int                      fold_count,
    output int                      checked_count
);

    typedef struct packed {
        logic [OPCODE_BITS-1:0] opcode;
        logic [63:0]            value;
        logic                   last;
    } instr_t;

    instr_t rewritten_q[$];

    // opcode table as the block should see it
    logic [OPCODE_BITS-1:0] code_push, code_nop, code_add, code_sub, code_mul, code_div;

    // window of held instructions
    int     window_fill;
    instr_t older_instr, newer_instr;

    // work out the rewritten instructions caused by one arriving instruction
    task automatic rewrite_instr(input instr_t in_instr);
        real         lhs, rhs;
        logic [63:0] sum_bits;
        logic        folds;
        folds = 1'b0;
        sum_bits = '0;
        if (window_fill == 2 && older_instr.opcode == code_push
                && newer_instr.opcode == code_push) begin
            lhs = $bitstoreal(older_instr.value);
            rhs = $bitstoreal(newer_instr.value);
            folds = 1'b1;
            if (in_instr.opcode == code_add)
                sum_bits = $realtobits(lhs + rhs);
            else if (in_instr.opcode == code_sub)
                sum_bits = $realtobits(lhs - rhs);
            else if (in_instr.opcode == code_mul)
                sum_bits = $realtobits(lhs * rhs);
            else if (in_instr.opcode == code_div && newer_instr.value[62:0] != '0)
                sum_bits = $realtobits(lhs / rhs);
            else
                folds = 1'b0;
        end
        if (folds) begin
            rewritten_q.push_back({code_push, sum_bits, 1'b0});
            rewritten_q.push_back({code_nop, newer_instr.value, 1'b0});
            rewritten_q.push_back({code_nop, in_instr.value, in_instr.last});
            window_fill = 0;
            fold_count++;
            return;
        end
        // oldest leaves when the window overflows
        if (window_fill == 2) begin
            rewritten_q.push_back({older_instr.opcode, older_instr.value, 1'b0});
            window_fill = 1;
        end
        if (window_fill == 1) begin
            older_instr = newer_instr;
            window_fill = 2;
        end else begin
            window_fill = 1;
        end
        newer_instr = in_instr;
        // last instruction flushes the window
        if (in_instr.last) begin
            if (window_fill == 2)
                rewritten_q.push_back({older_instr.opcode, older_instr.value, 1'b0});
            rewritten_q.push_back({newer_instr.opcode, newer_instr.value, 1'b1});
            window_fill = 0;
        end
    endtask

    always @(posedge aclk) begin
        instr_t want;
        if (!aresetn) begin
            code_push = PUSH_RST;
            code_nop  = NOP_RST;
            code_add  = ADD_RST;
            code_sub  = SUB_RST;
            code_mul  = MUL_RST;
            code_div  = DIV_RST;
            window_fill = 0;
            rewritten_q.delete();
            mismatch_count = 0;
            fold_count = 0;
            checked_count = 0;
        end else begin
            // compare the outgoing item first, it stems from earlier input
            if (m_valid && m_ready) begin
                checked_count++;
                if (rewritten_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected item opcode %0d value %h last %0b", $time,
                             m_out_opcode, m_out_value, m_out_last);
                end else begin
                    want = rewritten_q.pop_front();
                    if (m_out_opcode !== want.opcode) begin
                        mismatch_count++;
                        $display("%0t: opcode expected %0d actual %0d", $time,
                                 want.opcode, m_out_opcode);
                    end
                    if (m_out_value !== want.value) begin
                        mismatch_count++;
                        $display("%0t: value expected %h actual %h", $time,
                                 want.value, m_out_value);
                    end
                    if (m_out_last !== want.last) begin
                        mismatch_count++;
                        $display("%0t: last expected %0b actual %0b", $time,
                                 want.last, m_out_last);
                    end
                end
            end
            if (s_valid && s_ready)
                rewrite_instr({s_instr_opcode, s_instr_value, s_last_instr});
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PUSH: code_push = cfg_wr_data;
                    CFG_NOP:  code_nop  = cfg_wr_data;
                    CFG_ADD:  code_add  = cfg_wr_data;
                    CFG_SUB:  code_sub  = cfg_wr_data;
                    CFG_MUL:  code_mul  = cfg_wr_data;
                    CFG_DIV:  code_div  = cfg_wr_data;
                    default: ;
                endcase
            end
        end
        pending_count = rewritten_q.size();
    end

endmodule

// ===== test/tb_constant_fold_peephole.sv =====
// testbench top of the constant folding peephole: stimulus, pacing and verdict
`timescale 1ns / 1ps

module tb_constant_fold_peephole;
    import cfp_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_WAIT  = 300;
    localparam int PHASE_ITEMS  = 80;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [OPCODE_BITS-1:0]  cfg_wr_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [OPCODE_BITS-1:0]  s_instr_opcode;
    logic [63:0]             s_instr_value;
    logic                    s_last_instr;
    logic                    m_valid;
    logic                    m_ready;
    logic [OPCODE_BITS-1:0]  m_out_opcode;
    logic [63:0]             m_out_value;
    logic                    m_out_last;

    int pending_count, mismatch_count, fold_count, checked_count;
    int send_idle_pct, recv_stall_pct;
    int sent_count;
    int cycle_count;
    bit hold_trigger;

    // opcodes currently programmed, used to build programs
    logic [OPCODE_BITS-1:0] op_push, op_nop, op_add, op_sub, op_mul, op_div;

    constant_fold_peephole dut (.*);

    cfp_fold_checker checker_i (.*);

    // clock
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // receiver with random stalls and one long hold-off
    initial begin
        bit hold_done;
        hold_done = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_trigger && !hold_done) begin
                hold_done = 1;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // random binary64 operand, mixing special classes
    function automatic logic [63:0] rand_double();
        logic sign;
        sign = $urandom_range(1);
        case ($urandom_range(9))
            0: return {sign, 63'd0};
            1: return {sign, 11'h7FF, 52'd0};
            2: return {sign, 11'h7FF, 1'($urandom_range(1)), 19'($urandom), 32'($urandom) | 32'd1};
            3: return {sign, 11'd0, 20'($urandom), 32'($urandom)};
            4: return {32'($urandom), 32'($urandom)};
            5: return $urandom_range(1) ? {sign, 63'h7FEF_FFFF_FFFF_FFFF}
                                        : {sign, 11'd1, 52'd0};
            default: return {sign, 11'(1023 + $urandom_range(120) - 60),
                             20'($urandom), 32'($urandom)};
        endcase
    endfunction

    task automatic send_instr(input logic [7:0] opcode, input logic [63:0] value,
                              input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_instr_opcode <= opcode;
        s_instr_value  <= value;
        s_last_instr   <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
    endtask

    // let the block drain before touching the opcode table
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
    endtask

    task automatic write_code(input logic [CFG_IDX_BITS-1:0] idx,
                              input logic [OPCODE_BITS-1:0] code);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= code;
        @(posedge aclk);
        case (idx)
            CFG_PUSH: op_push = code;
            CFG_NOP:  op_nop  = code;
            CFG_ADD:  op_add  = code;
            CFG_SUB:  op_sub  = code;
            CFG_MUL:  op_mul  = code;
            CFG_DIV:  op_div  = code;
            default: ;
        endcase
    endtask

    // back to back register writes, enable dropped after the last one
    task automatic program_codes(input logic [7:0] p, n, a, s, m, d);
        write_code(CFG_PUSH, p);
        write_code(CFG_NOP, n);
        write_code(CFG_ADD, a);
        write_code(CFG_SUB, s);
        write_code(CFG_MUL, m);
        write_code(CFG_DIV, d);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly push/push/operation triples, the rest noise
    task automatic random_program(input int items);
        int   done_items;
        logic [7:0] arith_op;
        done_items = 0;
        while (done_items < items) begin
            if ($urandom_range(99) < 70) begin
                case ($urandom_range(3))
                    0: arith_op = op_add;
                    1: arith_op = op_sub;
                    2: arith_op = op_mul;
                    default: arith_op = op_div;
                endcase
                send_instr(op_push, rand_double(), $urandom_range(15) == 0);
                send_instr(op_push, rand_double(), $urandom_range(15) == 0);
                send_instr(arith_op, rand_double(), $urandom_range(7) == 0);
                done_items += 3;
            end else begin
                send_instr($urandom_range(3) == 0 ? op_push : 8'($urandom),
                           rand_double(), $urandom_range(9) == 0);
                done_items++;
            end
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_instr_opcode = '0;
        s_instr_value  = '0;
        s_last_instr   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_trigger   = 0;
        sent_count     = 0;
        cycle_count    = 0;
        op_push = PUSH_RST; op_nop = NOP_RST; op_add = ADD_RST;
        op_sub  = SUB_RST;  op_mul = MUL_RST; op_div = DIV_RST;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: each operation, zero divisors, specials, flushes
        send_instr(op_push, $realtobits(1.5), 0);
        send_instr(op_push, $realtobits(2.25), 0);
        send_instr(op_add, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_instr(op_push, $realtobits(10.0), 0);
        send_instr(op_push, $realtobits(3.0), 0);
        send_instr(op_sub, 64'd0, 0);
        send_instr(op_push, 64'h7FEF_FFFF_FFFF_FFFF, 0);
        send_instr(op_push, $realtobits(2.0), 0);
        send_instr(op_mul, 64'd0, 0);
        send_instr(op_push, $realtobits(1.0), 0);
        send_instr(op_push, $realtobits(3.0), 0);
        send_instr(op_div, 64'd1, 0);
        send_instr(op_push, $realtobits(1.0), 0);
        send_instr(op_push, 64'd0, 0);
        send_instr(op_div, 64'd0, 0);
        send_instr(op_push, $realtobits(1.0), 0);
        send_instr(op_push, 64'h8000_0000_0000_0000, 0);
        send_instr(op_div, 64'd0, 1);
        send_instr(op_push, $realtobits(4.0), 0);
        send_instr(op_push, 64'h7FF8_0000_0000_0001, 0);
        send_instr(op_div, 64'd0, 0);
        send_instr(op_push, 64'h7FF0_0000_0000_0000, 0);
        send_instr(op_push, 64'h7FF0_0000_0000_0000, 0);
        send_instr(op_sub, 64'd5, 1);
        send_instr(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1);

        // no idling, with one long hold-off while items keep coming
        hold_trigger = 1;
        random_program(PHASE_ITEMS);
        drain();

        // extremes and shared codes: add and sub share a value
        program_codes(8'hFF, 8'h00, 8'h07, 8'h07, 8'h80, 8'h09);
        send_idle_pct = 77;
        random_program(PHASE_ITEMS);
        drain();

        program_codes(8'($urandom), 8'($urandom), 8'h00, 8'hFE, 8'h55, 8'hAA);
        send_idle_pct  = 0;
        recv_stall_pct = 77;
        random_program(PHASE_ITEMS);
        drain();

        program_codes(8'h80, 8'hFF, 8'h01, 8'h02, 8'h02, 8'hFF);
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        random_program(PHASE_ITEMS);
        drain();

        $display("covered %0d instructions in, %0d items checked, %0d folds",
                 sent_count, checked_count, fold_count);
        $display("four opcode tables, idle and stall mixes and a long output hold-off");
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== constant_fold_peephole.f =====
+incdir+rtl
rtl/cfp_pkg.sv
rtl/cfp_fpu.sv
rtl/constant_fold_peephole.sv
test/cfp_fold_checker.sv
test/tb_constant_fold_peephole.sv
